### src/grid_astar_path_planner_defines.svh
// Assertion macros shared by the planner RTL.
`ifndef GRID_ASTAR_PATH_PLANNER_DEFINES_SVH
`define GRID_ASTAR_PATH_PLANNER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GAP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/gap_pkg.sv
`timescale 1ns / 1ps
package gap_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_PLAN  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_PATH = 2'd1,
      ST_EMPTY   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MARK_UNSEEN = 2'd0,
      MARK_OPEN   = 2'd1,
      MARK_CLOSED = 2'd2
   } mark_type;

   localparam logic [1:0] DIR_DOWN  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_UP    = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   localparam int FIELD_W = 5;
   localparam int LEN_W   = 10;
   localparam int DATA_W  = 24;

endpackage

### src/gap_ram.sv
`timescale 1ns / 1ps
module gap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/grid_astar_path_planner.sv
`timescale 1ns / 1ps
// Grid A* path planner.
// The req channel carries one command per transfer, selected by req_tuser: a map write
// sets one cell to wall or open, a plan searches from the start to the goal cell, and a
// read pops the next cell of the planned path. Every command returns exactly one rsp
// transfer with a status in rsp_tuser; rsp_tlast marks the read that returns the goal.
// A plan first sweeps the per-cell search memory, then repeats a scan of the open list
// (one entry per cycle) and an expansion of up to 4 neighbors, each read and then checked,
// and finally writes the path back, reading each step's parent entry and then writing the
// step. The search memory has a single read port; one command is processed at a time.
// After reset the wall map is cleared to open by a sweep over all ROWS*COLS cells, during
// which req_tready stays low. A finished result waits in the output register while
// rsp_tready is low; the next command is already taken, and its result is held back
// until the output register is free.
`include "grid_astar_path_planner_defines.svh"
module grid_astar_path_planner import gap_pkg::*; #(
   parameter int ROWS = 32,
   parameter int COLS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // cell_row[4:0], cell_col[9:5], cell_is_wall[10], goal_row[15:11], goal_col[20:16]
   input  logic [DATA_W-1:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]        req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // step_row[4:0], step_col[9:5], path_length[19:10]
   output logic [DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);

   localparam int CELLS  = ROWS * COLS;
   localparam int CELL_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS);
   localparam int COST_W = CNT_W;
   localparam int F_W    = COST_W + 2;
   localparam int RC_W   = ROW_W + COL_W;
   localparam int ENT_W  = 2 + COST_W + 2;

   typedef struct packed {
      logic [ROW_W-1:0] r;
      logic [COL_W-1:0] c;
   } rc_type;

   typedef struct packed {
      mark_type          mark;
      logic [COST_W-1:0] cost;
      logic [1:0]        par;
   } entry_type;

   typedef enum logic [3:0] {
      S_CLR_WALL, S_IDLE, S_CLR_MARK, S_INIT, S_SCAN, S_CLOSE,
      S_NB_RD, S_NB_CHK, S_PATH_RD, S_PATH_WR, S_READ_WAIT, S_DONE
   } state_type;

   function automatic logic [CELL_W-1:0] cell_idx(rc_type p);
      return CELL_W'(p.r) * CELL_W'(COLS) + CELL_W'(p.c);
   endfunction

   function automatic logic step_ok(rc_type p, logic [1:0] d);
      logic ok;
      unique case (d)
         DIR_DOWN:  ok = (int'(p.r) + 1) < ROWS;
         DIR_RIGHT: ok = (int'(p.c) + 1) < COLS;
         DIR_UP:    ok = (p.r != '0);
         default:   ok = (p.c != '0);
      endcase
      return ok;
   endfunction

   function automatic rc_type step_to(rc_type p, logic [1:0] d);
      rc_type q;
      q = p;
      unique case (d)
         DIR_DOWN:  q.r = p.r + 1'b1;
         DIR_RIGHT: q.c = p.c + 1'b1;
         DIR_UP:    q.r = p.r - 1'b1;
         default:   q.c = p.c - 1'b1;
      endcase
      return q;
   endfunction

   function automatic logic [F_W-1:0] fval(logic [COST_W-1:0] g, rc_type p, rc_type t);
      logic [ROW_W-1:0] dr;
      logic [COL_W-1:0] dc;
      dr = (p.r > t.r) ? p.r - t.r : t.r - p.r;
      dc = (p.c > t.c) ? p.c - t.c : t.c - p.c;
      return F_W'(g) + F_W'(dr) + F_W'(dc);
   endfunction

   state_type         state_ff, state_in;
   logic [CELL_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]  ctr_ff, ctr_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              v1_ff, v1_in, v2_ff, v2_in;
   rc_type            rc2_ff, rc2_in;
   logic              found_ff, found_in;
   rc_type            best_rc_ff, best_rc_in;
   logic [F_W-1:0]    best_f_ff, best_f_in;
   entry_type         best_ent_ff, best_ent_in;
   logic [1:0]        dir_ff, dir_in;
   rc_type            nb_ff, nb_in;
   rc_type            start_ff, start_in;
   rc_type            goal_ff, goal_in;
   rc_type            cur_ff, cur_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  plen_ff, plen_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   status_type        res_status_ff, res_status_in;
   logic [FIELD_W-1:0] res_row_ff, res_row_in, res_col_ff, res_col_in;
   logic [LEN_W-1:0]  res_len_ff, res_len_in;
   logic              res_last_ff, res_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              wall_we, wall_wdata, wall_rdata;
   logic [CELL_W-1:0] wall_waddr, wall_raddr;
   logic              ent_we;
   logic [CELL_W-1:0] ent_waddr, ent_raddr;
   entry_type         ent_wdata, ent_rdata;
   logic              list_we;
   logic [CELL_W-1:0] list_waddr, list_raddr;
   rc_type            list_wdata, list_rdata;
   logic              path_we;
   logic [CELL_W-1:0] path_waddr, path_raddr;
   rc_type            path_wdata, path_rdata;

   rc_type            req_rc, req_goal;
   logic              req_on_grid, goal_on_grid;
   logic [CNT_W-1:0]  rem_dec;
   logic [F_W-1:0]    f2;

   assign req_rc.r     = ROW_W'(req_tdata[4:0]);
   assign req_rc.c     = COL_W'(req_tdata[9:5]);
   assign req_goal.r   = ROW_W'(req_tdata[15:11]);
   assign req_goal.c   = COL_W'(req_tdata[20:16]);
   assign req_on_grid  = (int'(req_tdata[4:0]) < ROWS) && (int'(req_tdata[9:5]) < COLS);
   assign goal_on_grid = (int'(req_tdata[15:11]) < ROWS) && (int'(req_tdata[20:16]) < COLS);
   assign rem_dec      = rem_ff - 1'b1;
   assign f2           = fval(ent_rdata.cost, rc2_ff, goal_ff);

   gap_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall (
      .clock(clock), .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
      .raddr(wall_raddr), .rdata(wall_rdata)
   );

   gap_ram #(.WIDTH(ENT_W), .DEPTH(CELLS)) u_entry (
      .clock(clock), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
      .raddr(ent_raddr), .rdata(ent_rdata)
   );

   gap_ram #(.WIDTH(RC_W), .DEPTH(CELLS)) u_list (
      .clock(clock), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
      .raddr(list_raddr), .rdata(list_rdata)
   );

   gap_ram #(.WIDTH(RC_W), .DEPTH(CELLS)) u_path (
      .clock(clock), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
      .raddr(path_raddr), .rdata(path_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ctr_in        = ctr_ff;
      scan_in       = scan_ff;
      v1_in         = 1'b0;
      v2_in         = 1'b0;
      rc2_in        = rc2_ff;
      found_in      = found_ff;
      best_rc_in    = best_rc_ff;
      best_f_in     = best_f_ff;
      best_ent_in   = best_ent_ff;
      dir_in        = dir_ff;
      nb_in         = nb_ff;
      start_in      = start_ff;
      goal_in       = goal_ff;
      cur_in        = cur_ff;
      k_in          = k_ff;
      plen_in       = plen_ff;
      rem_in        = rem_ff;
      res_status_in = res_status_ff;
      res_row_in    = res_row_ff;
      res_col_in    = res_col_ff;
      res_len_in    = res_len_ff;
      res_last_in   = res_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;

      wall_we    = 1'b0;
      wall_waddr = cell_idx(req_rc);
      wall_wdata = req_tdata[10];
      wall_raddr = cell_idx(nb_ff);
      ent_we     = 1'b0;
      ent_waddr  = cell_idx(nb_ff);
      ent_wdata  = '{mark: MARK_OPEN, cost: COST_W'(best_ent_ff.cost + 1'b1), par: dir_ff};
      ent_raddr  = cell_idx(list_rdata);
      list_we    = 1'b0;
      list_waddr = ctr_ff[CELL_W-1:0];
      list_wdata = nb_ff;
      list_raddr = scan_ff[CELL_W-1:0];
      path_we    = 1'b0;
      path_waddr = k_ff[CELL_W-1:0];
      path_wdata = cur_ff;
      path_raddr = rem_dec[CELL_W-1:0];

      unique case (state_ff)
         S_CLR_WALL: begin
            wall_we    = 1'b1;
            wall_waddr = clr_ff;
            wall_wdata = 1'b0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == CELL_W'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               res_status_in = ST_OK;
               res_row_in    = '0;
               res_col_in    = '0;
               res_len_in    = '0;
               res_last_in   = 1'b0;
               state_in      = S_DONE;
               unique case (opcode_type'(req_tuser))
                  OP_WRITE: begin
                     wall_we = req_on_grid;
                  end
                  OP_PLAN: begin
                     rem_in   = '0;
                     ctr_in   = '0;
                     start_in = req_rc;
                     goal_in  = req_goal;
                     if (req_on_grid && goal_on_grid) begin
                        clr_in   = '0;
                        state_in = S_CLR_MARK;
                     end else begin
                        res_status_in = ST_NO_PATH;
                     end
                  end
                  OP_READ: begin
                     if (rem_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        rem_in   = rem_dec;
                        state_in = S_READ_WAIT;
                     end
                  end
                  OP_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CLR_MARK: begin
            ent_we    = 1'b1;
            ent_waddr = clr_ff;
            ent_wdata = '{mark: MARK_UNSEEN, cost: '0, par: '0};
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CELL_W'(CELLS - 1)) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            ent_we     = 1'b1;
            ent_waddr  = cell_idx(start_ff);
            ent_wdata  = '{mark: MARK_OPEN, cost: '0, par: '0};
            list_we    = 1'b1;
            list_waddr = '0;
            list_wdata = start_ff;
            ctr_in     = CNT_W'(1);
            scan_in    = '0;
            found_in   = 1'b0;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            if (scan_ff < ctr_ff) begin
               v1_in   = 1'b1;
               scan_in = scan_ff + 1'b1;
            end
            v2_in  = v1_ff;
            rc2_in = list_rdata;
            if (v2_ff && ent_rdata.mark == MARK_OPEN && (!found_ff || f2 < best_f_ff)) begin
               found_in    = 1'b1;
               best_rc_in  = rc2_ff;
               best_f_in   = f2;
               best_ent_in = ent_rdata;
            end
            if (scan_ff == ctr_ff && !v1_ff && !v2_ff) begin
               if (!found_ff) begin
                  res_status_in = ST_NO_PATH;
                  state_in      = S_DONE;
               end else if (best_rc_ff == goal_ff) begin
                  plen_in = best_ent_ff.cost;
                  rem_in  = best_ent_ff.cost;
                  cur_in  = goal_ff;
                  k_in    = '0;
                  if (best_ent_ff.cost == '0) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_PATH_RD;
                  end
               end else begin
                  state_in = S_CLOSE;
               end
            end
         end
         S_CLOSE: begin
            ent_we    = 1'b1;
            ent_waddr = cell_idx(best_rc_ff);
            ent_wdata = '{mark: MARK_CLOSED, cost: best_ent_ff.cost, par: best_ent_ff.par};
            dir_in    = DIR_DOWN;
            state_in  = S_NB_RD;
         end
         S_NB_RD: begin
            if (step_ok(best_rc_ff, dir_ff)) begin
               nb_in      = step_to(best_rc_ff, dir_ff);
               ent_raddr  = cell_idx(nb_in);
               wall_raddr = cell_idx(nb_in);
               state_in   = S_NB_CHK;
            end else if (dir_ff == DIR_LEFT) begin
               scan_in  = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end else begin
               dir_in = dir_ff + 1'b1;
            end
         end
         S_NB_CHK: begin
            if (!wall_rdata && ent_rdata.mark == MARK_UNSEEN) begin
               ent_we  = 1'b1;
               list_we = 1'b1;
               ctr_in  = ctr_ff + 1'b1;
            end
            if (dir_ff == DIR_LEFT) begin
               scan_in  = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end else begin
               dir_in   = dir_ff + 1'b1;
               state_in = S_NB_RD;
            end
         end
         S_PATH_RD: begin
            ent_raddr = cell_idx(cur_ff);
            state_in  = S_PATH_WR;
         end
         S_PATH_WR: begin
            path_we = 1'b1;
            cur_in  = step_to(cur_ff, ent_rdata.par ^ 2'b10);
            k_in    = k_ff + 1'b1;
            if (k_in == plen_ff) begin
               res_len_in = LEN_W'(plen_ff);
               state_in   = S_DONE;
            end else begin
               state_in = S_PATH_RD;
            end
         end
         S_READ_WAIT: begin
            res_row_in  = FIELD_W'(path_rdata.r);
            res_col_in  = FIELD_W'(path_rdata.c);
            res_len_in  = LEN_W'(rem_ff);
            res_last_in = (rem_ff == '0);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_row_in    = res_row_ff;
               rsp_col_in    = res_col_ff;
               rsp_len_in    = res_len_ff;
               rsp_last_in   = res_last_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR_WALL;
         clr_ff       <= '0;
         ctr_ff       <= '0;
         scan_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ctr_ff       <= ctr_in;
         scan_ff      <= scan_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         found_ff     <= found_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rc2_ff        <= rc2_in;
      best_rc_ff    <= best_rc_in;
      best_f_ff     <= best_f_in;
      best_ent_ff   <= best_ent_in;
      dir_ff        <= dir_in;
      nb_ff         <= nb_in;
      start_ff      <= start_in;
      goal_ff       <= goal_in;
      cur_ff        <= cur_in;
      k_ff          <= k_in;
      plen_ff       <= plen_in;
      res_status_ff <= res_status_in;
      res_row_ff    <= res_row_in;
      res_col_ff    <= res_col_in;
      res_len_ff    <= res_len_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(DATA_W - 2 * FIELD_W - LEN_W)'(0), rsp_len_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `GAP_ASSERT_IMPLY(a_ctr_bound, clock, reset, state_ff != S_IDLE, ctr_ff <= CNT_W'(CELLS), "open list count exceeds the grid size")
   `GAP_ASSERT_IMPLY(a_path_index, clock, reset, state_ff == S_PATH_WR, k_ff < plen_ff, "path write index passed the path length")
   `GAP_ASSERT_NEXT(a_read_pop, clock, reset, state_ff == S_IDLE && req_tvalid && req_tuser == OP_READ && rem_ff != '0, rem_ff == $past(rem_ff) - 1'b1, "read did not pop one path step")
   `GAP_ASSERT_NEXT(a_result_wait, clock, reset, state_ff == S_DONE && rsp_valid_ff && !rsp_tready, state_ff == S_DONE, "result left while output register was full")

endmodule

### tb/grid_astar_path_planner_tb.sv
`timescale 1ns / 1ps
module grid_astar_path_planner_tb;
   import gap_pkg::*;

   localparam int GRID_ROWS = 32;
   localparam int GRID_COLS = 32;
   localparam int CELLS = GRID_ROWS * GRID_COLS;
   localparam int STALL_LIMIT = 4000000;

   typedef struct {
      status_type         status;
      logic [4:0]         step_row;
      logic [4:0]         step_col;
      logic [LEN_W-1:0]   path_length;
      logic               last;
   } reply_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;
   logic [1:0]        req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              rsp_tlast;

   bit       wall_at [CELLS];
   mark_type mark_at [CELLS];
   int       cost_at [CELLS];
   int       order_at [CELLS];
   logic [1:0] parent_dir_at [CELLS];
   int       route_cells [CELLS];
   int       steps_left;
   int       insert_count;

   reply_type pending_replies[$];
   int       error_count;
   int       items_sent;
   bit       no_idle;
   bit       long_hold_req;
   int       hold_count;
   int       stall_cycles;

   grid_astar_path_planner #(.ROWS(GRID_ROWS), .COLS(GRID_COLS)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic bit step_cell(input int src, input logic [1:0] dir, output int to);
      int r;
      int c;
      r = src / GRID_COLS;
      c = src % GRID_COLS;
      to = 0;
      case (dir)
         DIR_DOWN: begin
            if (r + 1 >= GRID_ROWS) return 0;
            r++;
         end
         DIR_RIGHT: begin
            if (c + 1 >= GRID_COLS) return 0;
            c++;
         end
         DIR_UP: begin
            if (r == 0) return 0;
            r--;
         end
         default: begin
            if (c == 0) return 0;
            c--;
         end
      endcase
      to = r * GRID_COLS + c;
      return 1;
   endfunction

   function automatic int abs_diff(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Returns the number of path steps, or -1 when a coordinate is off the grid or the goal cannot be reached.
   function automatic int plan_route(input int sr, input int sc, input int gr, input int gc);
      int start_cell;
      int goal_cell;
      int best;
      int best_f;
      int best_order;
      int f;
      int n;
      int node;
      int len;
      logic [1:0] back_dir;
      for (int k = 0; k < CELLS; k++) mark_at[k] = MARK_UNSEEN;
      insert_count = 0;
      steps_left = 0;
      if (sr >= GRID_ROWS || sc >= GRID_COLS || gr >= GRID_ROWS || gc >= GRID_COLS)
         return -1;
      start_cell = sr * GRID_COLS + sc;
      goal_cell = gr * GRID_COLS + gc;
      mark_at[start_cell] = MARK_OPEN;
      cost_at[start_cell] = 0;
      order_at[start_cell] = insert_count++;
      while (1) begin
         best = -1;
         best_f = 0;
         best_order = 0;
         for (int k = 0; k < CELLS; k++) begin
            if (mark_at[k] != MARK_OPEN) continue;
            f = cost_at[k] + abs_diff(k / GRID_COLS, gr) + abs_diff(k % GRID_COLS, gc);
            if (best < 0 || f < best_f || (f == best_f && order_at[k] < best_order)) begin
               best = k;
               best_f = f;
               best_order = order_at[k];
            end
         end
         if (best < 0) return -1;
         if (best == goal_cell) break;
         mark_at[best] = MARK_CLOSED;
         for (int d = 0; d < 4; d++) begin
            if (!step_cell(best, d[1:0], n) || wall_at[n] || mark_at[n] != MARK_UNSEEN)
               continue;
            mark_at[n] = MARK_OPEN;
            cost_at[n] = cost_at[best] + 1;
            order_at[n] = insert_count++;
            parent_dir_at[n] = d[1:0];
         end
      end
      len = cost_at[goal_cell];
      if (len > CELLS) len = CELLS;
      node = goal_cell;
      for (int k = 0; k < len; k++) begin
         route_cells[k] = node;
         back_dir = parent_dir_at[node] + DIR_UP;
         if (!step_cell(node, back_dir, n)) begin
            len = k + 1;
            break;
         end
         node = n;
      end
      steps_left = len;
      return len;
   endfunction

   function automatic reply_type predict_reply(input opcode_type op, input int r, input int c,
                                               input int w, input int gr, input int gc);
      reply_type rep;
      int len;
      int pos;
      rep = '{ST_OK, 5'd0, 5'd0, '0, 1'b0};
      case (op)
         OP_WRITE: begin
            if (r < GRID_ROWS && c < GRID_COLS) wall_at[r * GRID_COLS + c] = w[0];
         end
         OP_PLAN: begin
            len = plan_route(r, c, gr, gc);
            if (len < 0) rep.status = ST_NO_PATH;
            else rep.path_length = len[LEN_W-1:0];
         end
         OP_READ: begin
            if (steps_left == 0 || steps_left > CELLS) begin
               steps_left = 0;
               rep.status = ST_EMPTY;
            end else begin
               steps_left--;
               pos = route_cells[steps_left] % CELLS;
               rep.step_row = 5'(pos / GRID_COLS);
               rep.step_col = 5'(pos % GRID_COLS);
               rep.path_length = steps_left[LEN_W-1:0];
               rep.last = (steps_left == 0);
            end
         end
         default: ;
      endcase
      return rep;
   endfunction

   task automatic send_item(input opcode_type op, input int r, input int c, input int w,
                            input int gr, input int gc);
      pending_replies = {pending_replies, predict_reply(op, r, c, w, gr, gc)};
      req_tuser <= op;
      req_tdata <= {3'b000, gc[4:0], gr[4:0], w[0], c[4:0], r[4:0]};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic drain_route(input int extra);
      int n;
      n = steps_left + extra;
      repeat (n) send_item(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 1), $urandom_range(0, 31), $urandom_range(0, 31));
   endtask

   function automatic int near_coord(input int v);
      int x;
      x = v + $urandom_range(0, 10) - 5;
      if (x < 0) x = 0;
      if (x > 31) x = 31;
      return x;
   endfunction

   task automatic test_directed;
      send_item(OP_READ, 0, 0, 0, 0, 0);
      send_item(OP_NONE, 31, 31, 1, 31, 31);
      send_item(OP_WRITE, 31, 31, 1, 31, 31);
      send_item(OP_WRITE, 0, 0, 1, 0, 0);
      send_item(OP_PLAN, 0, 0, 0, 0, 2);
      drain_route(1);
      send_item(OP_WRITE, 0, 1, 1, 0, 0);
      send_item(OP_WRITE, 1, 1, 1, 0, 0);
      send_item(OP_PLAN, 2, 0, 0, 0, 3);
      send_item(OP_WRITE, 2, 2, 1, 0, 0);
      drain_route(1);
      send_item(OP_PLAN, 5, 5, 0, 5, 5);
      send_item(OP_READ, 5, 5, 0, 5, 5);
      send_item(OP_PLAN, 30, 30, 0, 31, 31);
      send_item(OP_READ, 0, 0, 0, 0, 0);
      send_item(OP_WRITE, 0, 0, 0, 0, 0);
      send_item(OP_WRITE, 31, 31, 0, 0, 0);
   endtask

   task automatic test_unreachable;
      send_item(OP_WRITE, 3, 3, 1, 0, 0);
      send_item(OP_PLAN, 3, 0, 0, 3, 3);
      send_item(OP_READ, 0, 0, 0, 0, 0);
      send_item(OP_WRITE, 3, 3, 0, 0, 0);
   endtask

   task automatic test_random_plans(input int item_goal);
      int sr;
      int sc;
      int gr;
      int gc;
      int pick;
      while (items_sent < item_goal) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            repeat ($urandom_range(1, 4))
               send_item(OP_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 1), $urandom_range(0, 31), $urandom_range(0, 31));
         end else if (pick < 9) begin
            sr = $urandom_range(0, 31);
            sc = $urandom_range(0, 31);
            gr = near_coord(sr);
            gc = near_coord(sc);
            for (int t = 0; t < 8 && wall_at[gr * GRID_COLS + gc]; t++) begin
               gr = near_coord(sr);
               gc = near_coord(sc);
            end
            if (wall_at[gr * GRID_COLS + gc]) continue;
            send_item(OP_PLAN, sr, sc, $urandom_range(0, 1), gr, gc);
            drain_route($urandom_range(0, 3) == 0 ? -$urandom_range(0, 2) : 1);
         end else begin
            send_item(opcode_type'($urandom_range(0, 3) == 1 ? OP_READ : $urandom_range(0, 3)),
                      $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1),
                      $urandom_range(0, 31), $urandom_range(0, 31));
         end
      end
   endtask

   task automatic test_backpressure;
      long_hold_req = 1'b1;
      send_item(OP_PLAN, 10, 10, 0, 12, 13);
      drain_route(2);
      repeat (4) send_item(OP_WRITE, $urandom_range(0, 31), $urandom_range(0, 31), 0, 0, 0);
   endtask

   task automatic test_no_idle;
      no_idle = 1'b1;
      send_item(OP_PLAN, 20, 4, 0, 17, 8);
      drain_route(1);
      test_random_plans(items_sent + 25);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_count <= 0;
      end else if (long_hold_req) begin
         long_hold_req <= 1'b0;
         hold_count <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
         hold_count <= $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected transfer tuser=%0d tdata=%h tlast=%b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[4:0] !== want.step_row) begin
               $display("%0t: step_row expected %0d actual %0d",
                        $time, want.step_row, rsp_tdata[4:0]);
               error_count++;
            end
            if (rsp_tdata[9:5] !== want.step_col) begin
               $display("%0t: step_col expected %0d actual %0d",
                        $time, want.step_col, rsp_tdata[9:5]);
               error_count++;
            end
            if (rsp_tdata[19:10] !== want.path_length) begin
               $display("%0t: path_length expected %0d actual %0d",
                        $time, want.path_length, rsp_tdata[19:10]);
               error_count++;
            end
            if (rsp_tdata[DATA_W-1:20] !== '0) begin
               $display("%0t: tdata pad expected 0 actual %h", $time, rsp_tdata[DATA_W-1:20]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_NONE;
      error_count = 0;
      items_sent = 0;
      no_idle = 1'b0;
      long_hold_req = 1'b0;
      steps_left = 0;
      insert_count = 0;
      for (int k = 0; k < CELLS; k++) begin
         wall_at[k] = 1'b0;
         mark_at[k] = MARK_UNSEEN;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed;
      test_unreachable;
      test_backpressure;
      test_random_plans(265);
      test_no_idle;
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
